[design/fpa_pkg.sv]
// Shared types and opcodes for the Q17.14 fixed-point ALU.
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_I2F       = 4'd0,
    CMD_F2I_TRUNC = 4'd1,
    CMD_F2I_ROUND = 4'd2,
    CMD_ADD       = 4'd3,
    CMD_SUB       = 4'd4,
    CMD_ADD_INT   = 4'd5,
    CMD_SUB_INT   = 4'd6,
    CMD_MUL       = 4'd7,
    CMD_MUL_INT   = 4'd8,
    CMD_DIV       = 4'd9,
    CMD_DIV_INT   = 4'd10
  } cmd_e;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               div_zero;
  } alu_out_t;

  // Side data that rides along the divider chain.
  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] simple;
    logic [63:0] product;
    logic [31:0] divisor;
    logic        neg_q;
    logic        dz;
  } side_t;

endpackage
`default_nettype wire

[design/fpa_front.sv]
// Front stage: multiplier, add/shift operations and divider setup.
`default_nettype none
module fpa_front import fpa_pkg::*; #(
  parameter int FracBits = 14,
  parameter int DW       = 32 + FracBits
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire alu_in_t       data_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [DW-1:0]      dq_o
);

  localparam logic [33:0] Half = 34'(1) << (FracBits - 1);
  localparam logic [31:0] Bias = (32'(1) << FracBits) - 32'(1);

  logic signed [31:0] a, b;
  logic [33:0]        mag_a, rnd;
  logic [31:0]        abs_a;
  side_t              side_d;
  logic [DW-1:0]      dq_d;

  assign a = data_i.operand_a;
  assign b = data_i.operand_b;
  assign abs_a = a[31] ? 32'(-a) : 32'(a);
  assign mag_a = a[31] ? 34'(-{{2{a[31]}}, a}) : {2'b00, a};
  assign rnd   = (mag_a + Half) >> FracBits;

  always_comb begin
    side_d.cmd     = data_i.cmd;
    side_d.product = 64'($signed(a) * $signed(b));
    side_d.divisor = b[31] ? 32'(-b) : 32'(b);
    side_d.neg_q   = a[31] ^ b[31];
    side_d.dz      = ((data_i.cmd == CMD_DIV) || (data_i.cmd == CMD_DIV_INT)) && (b == 32'sd0);
    case (data_i.cmd)
      CMD_I2F:       side_d.simple = 32'(a <<< FracBits);
      CMD_F2I_TRUNC: side_d.simple = a[31] ? 32'((a + $signed(Bias)) >>> FracBits)
                                           : 32'(a >>> FracBits);
      CMD_F2I_ROUND: side_d.simple = a[31] ? 32'(-rnd) : rnd[31:0];
      CMD_ADD:       side_d.simple = 32'(a + b);
      CMD_SUB:       side_d.simple = 32'(a - b);
      CMD_ADD_INT:   side_d.simple = 32'(a + (b <<< FracBits));
      CMD_SUB_INT:   side_d.simple = 32'(a - (b <<< FracBits));
      default:       side_d.simple = 32'd0;
    endcase
    if (data_i.cmd == CMD_DIV) begin
      dq_d = DW'(abs_a) << FracBits;
    end else begin
      dq_d = DW'(abs_a);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_d;
      dq_o   <= dq_d;
    end
  end

endmodule
`default_nettype wire

[design/fpa_cell.sv]
// Divider cell: one restoring quotient bit per cycle while en_i is high.
`default_nettype none
module fpa_cell import fpa_pkg::*; #(
  parameter int DW = 46
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire side_t         side_i,
  input  wire logic [31:0]   rem_i,
  input  wire logic [DW-1:0] dq_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [31:0]        rem_o,
  output logic [DW-1:0]      dq_o
);

  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_i, dq_i[DW-1]};
  assign diff  = trial - {1'b0, side_i.divisor};
  assign ge    = trial >= {1'b0, side_i.divisor};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      rem_o  <= ge ? diff[31:0] : trial[31:0];
      dq_o   <= {dq_i[DW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

[design/fpa_back.sv]
// Back stage: product scaling, quotient sign and output register.
`default_nettype none
module fpa_back import fpa_pkg::*; #(
  parameter int FracBits = 14,
  parameter int DW       = 32 + FracBits
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire side_t         side_i,
  input  wire logic [DW-1:0] dq_i,
  output logic               valid_o,
  output alu_out_t           data_o
);

  localparam logic [63:0] Bias = (64'(1) << FracBits) - 64'(1);

  logic [63:0] scaled;
  alu_out_t    data_d;

  // Round the product toward zero before dropping the fraction.
  assign scaled = side_i.product + (side_i.product[63] ? Bias : 64'd0);

  always_comb begin
    data_d.div_zero = side_i.dz;
    case (side_i.cmd)
      CMD_MUL:     data_d.result = scaled[FracBits+31:FracBits];
      CMD_MUL_INT: data_d.result = side_i.product[31:0];
      CMD_DIV, CMD_DIV_INT: begin
        if (side_i.dz) begin
          data_d.result = 32'sd0;
        end else begin
          data_d.result = side_i.neg_q ? 32'(-dq_i[31:0]) : dq_i[31:0];
        end
      end
      default:     data_d.result = side_i.simple;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule
`default_nettype wire

[design/fixed_point_17_14_alu_unit.sv]
// Pipeline: front stage, one divider cell per dividend bit (32 + FRAC_BITS cells),
// output register.
// Throughput: one beat per cycle; the whole chain advances unless the output
// register holds a beat that is not taken.
// Reset: rst_ni clears all valid bits asynchronously; payload is not reset.
`default_nettype none
module fixed_point_17_14_alu_unit import fpa_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire alu_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output alu_out_t      out_data_o
);

  localparam int DW = 32 + FRAC_BITS;

  logic          en;
  logic          vld  [DW+1];
  side_t         side [DW+1];
  logic [31:0]   rem  [DW+1];
  logic [DW-1:0] dq   [DW+1];

  // Advance everything unless the output beat is stalled.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign rem[0]     = 32'd0;

  fpa_front #(.FracBits(FRAC_BITS), .DW(DW)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .data_i(in_data_i),
    .valid_o(vld[0]), .side_o(side[0]), .dq_o(dq[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    fpa_cell #(.DW(DW)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vld[i]), .side_i(side[i]), .rem_i(rem[i]), .dq_i(dq[i]),
      .valid_o(vld[i+1]), .side_o(side[i+1]), .rem_o(rem[i+1]), .dq_o(dq[i+1])
    );
  end

  fpa_back #(.FracBits(FRAC_BITS), .DW(DW)) u_back (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(vld[DW]), .side_i(side[DW]), .dq_i(dq[DW]),
    .valid_o(out_valid_o), .data_o(out_data_o)
  );

endmodule
`default_nettype wire
